[rtl/core/sbc_pkg.sv]
package sbc_pkg;

  localparam int WORD_W      = 32;
  localparam int BLOCK_WORDS = 16;
  localparam int CHAIN_WORDS = 8;
  localparam int NUM_ROUNDS  = 64;
  localparam int CNT_W       = $clog2(BLOCK_WORDS);
  localparam int ROUND_W     = $clog2(NUM_ROUNDS);
  localparam int IDX_W       = $clog2(CHAIN_WORDS);
  localparam int CFG_IDX_W   = 4;

  // Control from the sequencer to the datapath, one cycle at a time
  typedef struct packed {
    logic               load_iv;    // copy IV registers into the chaining value
    logic               shift_in;   // push one message word into the schedule window
    logic               init_work;  // copy chaining value into the working variables
    logic               round_en;   // run one compression round
    logic [ROUND_W-1:0] round_idx;  // round number for the constant table
    logic               finalize;   // add working variables into the chaining value
    logic               out_shift;  // advance the digest bank by one word
  } sbc_cmd_t;

  localparam logic [WORD_W-1:0] IV_RESET [CHAIN_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

[rtl/core/sbc_ctrl.sv]
module sbc_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic                     in_new_msg,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic                     out_tlast,
  output logic [sbc_pkg::IDX_W-1:0] out_idx,
  output sbc_pkg::sbc_cmd_t        cmd
);

  localparam logic [1:0] ST_COLLECT = 2'd0;
  localparam logic [1:0] ST_ROUND   = 2'd1;
  localparam logic [1:0] ST_FINAL   = 2'd2;

  localparam logic [sbc_pkg::CNT_W-1:0]   CNT_LAST   = sbc_pkg::CNT_W'(sbc_pkg::BLOCK_WORDS - 1);
  localparam logic [sbc_pkg::ROUND_W-1:0] ROUND_LAST = sbc_pkg::ROUND_W'(sbc_pkg::NUM_ROUNDS - 1);
  localparam logic [sbc_pkg::IDX_W-1:0]   IDX_LAST   = sbc_pkg::IDX_W'(sbc_pkg::CHAIN_WORDS - 1);

  logic [1:0]                   state_r, state_nxt;
  logic [sbc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [sbc_pkg::ROUND_W-1:0]  rnd_r, rnd_nxt;
  logic                         ovld_r, ovld_nxt;
  logic [sbc_pkg::IDX_W-1:0]    oidx_r, oidx_nxt;
  logic                         in_fire, out_fire, last_word;

  // Hold off the closing word of a block until the previous digest has drained
  assign last_word = (cnt_r == CNT_LAST);
  assign in_tready = (state_r == ST_COLLECT) && !(last_word && ovld_r);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = ovld_r && out_tready;

  assign out_tvalid = ovld_r;
  assign out_idx    = oidx_r;
  assign out_tlast  = (oidx_r == IDX_LAST);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rnd_nxt   = rnd_r;
    ovld_nxt  = ovld_r;
    oidx_nxt  = oidx_r;

    if (out_fire) begin
      oidx_nxt = oidx_r + 1'b1;
      if (oidx_r == IDX_LAST) begin
        ovld_nxt = 1'b0;
      end
    end

    unique case (state_r)
      ST_COLLECT: begin
        if (in_fire) begin
          cnt_nxt = cnt_r + 1'b1;
          if (last_word) begin
            state_nxt = ST_ROUND;
            rnd_nxt   = '0;
          end
        end
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_nxt = ST_COLLECT;
        ovld_nxt  = 1'b1;
        oidx_nxt  = '0;
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load_iv   = in_fire && (cnt_r == '0) && in_new_msg;
    cmd.shift_in  = in_fire;
    cmd.init_work = in_fire && last_word;
    cmd.round_en  = (state_r == ST_ROUND);
    cmd.round_idx = rnd_r;
    cmd.finalize  = (state_r == ST_FINAL);
    cmd.out_shift = out_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      cnt_r   <= '0;
      rnd_r   <= '0;
      ovld_r  <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rnd_r   <= rnd_nxt;
      ovld_r  <= ovld_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  a_bank_free_on_finalize: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finalize |-> !ovld_r)
    else $error("digest bank overwritten before it drained");

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_word) |=> (state_r == ST_ROUND) && (rnd_r == '0))
    else $error("closing word did not start the round sequence");

  a_rounds_end_in_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == ROUND_LAST) |=> (state_r == ST_FINAL))
    else $error("round sequence did not end in the chaining add");

  a_digest_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast) |=> !ovld_r)
    else $error("digest still valid after its last beat");

  a_count_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_word) |=> (cnt_r == '0))
    else $error("word count did not wrap at the end of a block");

endmodule

[rtl/core/sbc_dp.sv]
module sbc_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sbc_pkg::sbc_cmd_t             cmd,
  input  logic [sbc_pkg::WORD_W-1:0]    msg_word,
  input  logic                          cfg_we,
  input  logic [sbc_pkg::IDX_W-1:0]     cfg_sel,
  input  logic [sbc_pkg::WORD_W-1:0]    cfg_word,
  output logic [sbc_pkg::WORD_W-1:0]    digest_word
);

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  logic [sbc_pkg::WORD_W-1:0] iv_r    [sbc_pkg::CHAIN_WORDS];
  logic [sbc_pkg::WORD_W-1:0] chain_r [sbc_pkg::CHAIN_WORDS];
  logic [sbc_pkg::WORD_W-1:0] work_r  [sbc_pkg::CHAIN_WORDS];
  logic [sbc_pkg::WORD_W-1:0] sched_r [sbc_pkg::BLOCK_WORDS];
  logic [sbc_pkg::WORD_W-1:0] bank_r  [sbc_pkg::CHAIN_WORDS];
  logic [sbc_pkg::WORD_W-1:0] sum     [sbc_pkg::CHAIN_WORDS];

  logic [sbc_pkg::WORD_W-1:0] w_new, t1, t2, ch, maj, a_w, e_w;

  assign a_w = work_r[0];
  assign e_w = work_r[4];
  assign ch  = (e_w & work_r[5]) ^ (~e_w & work_r[6]);
  assign maj = (a_w & work_r[1]) ^ (a_w & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1  = work_r[7] + big_sig1(e_w) + ch
               + sbc_pkg::ROUND_K[cmd.round_idx] + sched_r[0];
  assign t2  = big_sig0(a_w) + maj;

  // Next schedule word from the sliding window: W[t-16], W[t-15], W[t-7], W[t-2]
  assign w_new = sched_r[0] + small_sig0(sched_r[1]) + sched_r[9] + small_sig1(sched_r[14]);

  assign digest_word = bank_r[0];

  always_comb begin
    for (int i = 0; i < sbc_pkg::CHAIN_WORDS; i++) begin
      sum[i] = chain_r[i] + work_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbc_pkg::CHAIN_WORDS; i++) begin
        iv_r[i]    <= sbc_pkg::IV_RESET[i];
        chain_r[i] <= sbc_pkg::IV_RESET[i];
      end
    end else begin
      if (cfg_we) begin
        iv_r[cfg_sel] <= cfg_word;
      end
      if (cmd.load_iv) begin
        for (int i = 0; i < sbc_pkg::CHAIN_WORDS; i++) begin
          chain_r[i] <= iv_r[i];
        end
      end else if (cmd.finalize) begin
        for (int i = 0; i < sbc_pkg::CHAIN_WORDS; i++) begin
          chain_r[i] <= sum[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_in || cmd.round_en) begin
      for (int i = 0; i < sbc_pkg::BLOCK_WORDS - 1; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[sbc_pkg::BLOCK_WORDS-1] <= cmd.round_en ? w_new : msg_word;
    end

    if (cmd.init_work) begin
      for (int i = 0; i < sbc_pkg::CHAIN_WORDS; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (cmd.round_en) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end

    if (cmd.finalize) begin
      for (int i = 0; i < sbc_pkg::CHAIN_WORDS; i++) begin
        bank_r[i] <= sum[i];
      end
    end else if (cmd.out_shift) begin
      for (int i = 0; i < sbc_pkg::CHAIN_WORDS - 1; i++) begin
        bank_r[i] <= bank_r[i+1];
      end
    end
  end

endmodule

[rtl/core/sha256_block_compress_top.sv]
// SHA-256 compression engine. Feed an already padded message as 32-bit words, most
// significant byte first, 16 beats per 512-bit block; set in_tuser on the first beat
// of a block to start a new message from the IV registers (ignored on other beats,
// and leaving it low on a first beat chains from the running hash). After the 16th
// beat the engine runs the 64 rounds through one round unit at one round per cycle,
// expanding the schedule in a 16-word sliding window alongside, then adds the
// working variables into the chaining value; no input word is accepted until
// that add is done. The eight digest words a..h then drain from a separate
// output bank (out_tuser = word index, out_tlast on h) while the next block's
// words are already accepted; only the 16th word of the next block waits until
// that digest is fully taken. The IV registers (cfg_index 0..7) reset to the
// SHA-256 initial value; load the SHA-224 value to get SHA-224 (all eight words
// still come out). Writes to index 8 and above are dropped.
// Write them only while the engine is idle.
module sha256_block_compress_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // [31:0] msg_word
  input  logic                               in_tuser,   // [0] new_message
  // digest stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [31:0]                        out_tdata,  // [31:0] digest_word
  output logic [2:0]                         out_tuser,  // [2:0] digest_index
  output logic                               out_tlast,  // digest_last
  // IV register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);

  sbc_pkg::sbc_cmd_t             cmd;
  logic                          cfg_we;
  logic [sbc_pkg::IDX_W-1:0]     out_idx;

  // Take every register beat at once; only indexes inside the IV bank land
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && (cfg_index < sbc_pkg::CFG_IDX_W'(sbc_pkg::CHAIN_WORDS));
  assign out_tuser = out_idx;

  sbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_new_msg (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_idx    (out_idx),
    .cmd        (cmd)
  );

  sbc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .msg_word    (in_tdata),
    .cfg_we      (cfg_we),
    .cfg_sel     (cfg_index[sbc_pkg::IDX_W-1:0]),
    .cfg_word    (cfg_data),
    .digest_word (out_tdata)
  );

endmodule
